// File: rtl/bmg_pkg.sv
// ----------------------------------------------------------------------------
// bmg_pkg: shared types and constants for the Box-Muller generator
// Fixed-point constants, stage counts, config register codes and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package bmg_pkg;

  // stage counts
  localparam int unsigned LogSteps    = 30;
  localparam int unsigned SqrtSteps   = 31;
  localparam int unsigned CordicSteps = 30;

  // latencies in cycles, input edge to registered output of each unit
  localparam int unsigned RadiusLat = LogSteps + SqrtSteps + 4;
  localparam int unsigned AngleLat  = CordicSteps + 2;
  localparam int unsigned ScaleLat  = 3;
  localparam int unsigned TrigDelay = RadiusLat - AngleLat;
  localparam int unsigned TotalLat  = RadiusLat + ScaleLat;

  // fixed-point constants
  localparam logic [28:0]        TwoLn2Q28  = 29'd372130559;
  localparam logic [30:0]        HalfPiQ30  = 31'd1686629713;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [31:0]        StdDevRst  = 32'd65536;

  // config register indexes
  typedef enum logic [0:0] {
    CfgMean   = 1'b0,
    CfgStdDev = 1'b1
  } cfg_reg_t;

  // control travelling with each request
  typedef struct packed {
    logic valid;
    logic keep;
  } ctl_t;

  // atan(2^-i) in Q2.30
  function automatic logic signed [33:0] atan_q30(input int unsigned i);
    logic signed [33:0] a;
    case (i)
      0:  a = 34'sh03243F6A8;
      1:  a = 34'sh01DAC6705;
      2:  a = 34'sh00FADBAFC;
      3:  a = 34'sh007F56EA6;
      4:  a = 34'sh003FEAB76;
      5:  a = 34'sh001FFD55B;
      6:  a = 34'sh000FFFAAA;
      7:  a = 34'sh0007FFF55;
      8:  a = 34'sh0003FFFEA;
      9:  a = 34'sh0001FFFFD;
      10: a = 34'sh0000FFFFF;
      11: a = 34'sh00007FFFF;
      12: a = 34'sh00003FFFF;
      13: a = 34'sh00001FFFF;
      14: a = 34'sh00000FFFF;
      15: a = 34'sh000007FFF;
      16: a = 34'sh000003FFF;
      17: a = 34'sh000001FFF;
      18: a = 34'sh000000FFF;
      19: a = 34'sh0000007FF;
      20: a = 34'sh0000003FF;
      21: a = 34'sh0000001FF;
      22: a = 34'sh0000000FF;
      23: a = 34'sh00000007F;
      24: a = 34'sh00000003F;
      25: a = 34'sh00000001F;
      26: a = 34'sh00000000F;
      27: a = 34'sh000000008;
      28: a = 34'sh000000004;
      default: a = 34'sh000000002;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/bmg_radius.sv
// ----------------------------------------------------------------------------
// bmg_radius: radius sqrt(-2 ln u) in Q3.28
// Normalise, 30 squaring stages for log2, scale by 2 ln 2, then a
// bit-per-stage square root. Control bits travel alongside.
// ----------------------------------------------------------------------------
module bmg_radius (
  input  logic             clk,
  input  logic             rst,
  input  bmg_pkg::ctl_t    in_ctl,
  input  logic [31:0]      uniform_u,
  output bmg_pkg::ctl_t    out_ctl,
  output logic [30:0]      radius
);

  localparam int unsigned NLog  = bmg_pkg::LogSteps;
  localparam int unsigned NSqrt = bmg_pkg::SqrtSteps;

  logic [31:0]   code;
  logic [4:0]    msb_idx;
  logic [31:0]   norm;

  logic [31:0]   lm [0:NLog];
  logic [29:0]   lf [0:NLog];
  logic [4:0]    le [0:NLog];
  bmg_pkg::ctl_t lc [0:NLog];

  logic [35:0]   t_q;
  bmg_pkg::ctl_t t_ctl;
  logic [46:0]   ph;
  logic [46:0]   pl;
  bmg_pkg::ctl_t p_ctl;
  logic [64:0]   wsum;

  logic [61:0]   sr  [0:NSqrt];
  logic [30:0]   rt  [0:NSqrt];
  bmg_pkg::ctl_t sc  [0:NSqrt];

  // normalise: zero code counts as one, mantissa to Q1.31
  always_comb begin
    code    = (uniform_u == 32'd0) ? 32'd1 : uniform_u;
    msb_idx = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (code[i]) msb_idx = 5'(i);
    end
    norm = code << (5'd31 - msb_idx);
  end

  always_ff @(posedge clk) begin
    lm[0] <= norm;
    lf[0] <= '0;
    le[0] <= msb_idx;
    if (rst) lc[0] <= '0;
    else     lc[0] <= in_ctl;
  end

  // one squaring per stage, one fraction bit each
  for (genvar g = 0; g < NLog; g++) begin : g_log
    logic [63:0] prod;
    logic [32:0] sq;
    assign prod = 64'(lm[g]) * 64'(lm[g]);
    assign sq   = prod[63:31];
    always_ff @(posedge clk) begin
      lm[g+1] <= sq[32] ? sq[32:1] : sq[31:0];
      lf[g+1] <= {lf[g][28:0], sq[32]};
      le[g+1] <= le[g];
      if (rst) lc[g+1] <= '0;
      else     lc[g+1] <= lc[g];
    end
  end

  // -log2(u) in Q.30, then split multiply by 2 ln 2
  always_ff @(posedge clk) begin
    t_q <= {6'd32 - {1'b0, le[NLog]}, 30'd0} - {6'd0, lf[NLog]};
    ph  <= 47'(t_q[35:18]) * 47'(bmg_pkg::TwoLn2Q28);
    pl  <= 47'(t_q[17:0]) * 47'(bmg_pkg::TwoLn2Q28);
    if (rst) begin
      t_ctl <= '0;
      p_ctl <= '0;
    end else begin
      t_ctl <= lc[NLog];
      p_ctl <= t_ctl;
    end
  end

  // -2 ln u in Q.30, shifted up as the root operand
  assign wsum = (65'(ph) << 18) + 65'(pl);

  always_ff @(posedge clk) begin
    sr[0] <= {wsum[63:28], 26'd0};
    rt[0] <= '0;
    if (rst) sc[0] <= '0;
    else     sc[0] <= p_ctl;
  end

  // restoring square root, one result bit per stage, msb first
  for (genvar g = 0; g < NSqrt; g++) begin : g_sqrt
    localparam int unsigned K = NSqrt - 1 - g;
    logic [63:0] trial;
    logic [63:0] diff;
    logic        fits;
    assign trial = (64'(rt[g]) << (K + 1)) + (64'd1 << (2 * K));
    assign fits  = 64'(sr[g]) >= trial;
    assign diff  = 64'(sr[g]) - trial;
    always_ff @(posedge clk) begin
      sr[g+1] <= fits ? diff[61:0] : sr[g];
      rt[g+1] <= fits ? (rt[g] | (31'd1 << K)) : rt[g];
      if (rst) sc[g+1] <= '0;
      else     sc[g+1] <= sc[g];
    end
  end

  assign radius  = rt[NSqrt];
  assign out_ctl = sc[NSqrt];

endmodule

// File: rtl/bmg_sincos.sv
// ----------------------------------------------------------------------------
// bmg_sincos: cos and sin of 2*pi*v in Q2.30
// Angle within the quadrant, 30 unrolled CORDIC stages, quadrant fold-out.
// ----------------------------------------------------------------------------
module bmg_sincos (
  input  logic               clk,
  input  logic [31:0]        uniform_v,
  output logic signed [33:0] cos_val,
  output logic signed [33:0] sin_val
);

  localparam int unsigned N = bmg_pkg::CordicSteps;

  logic [60:0]        zprod;
  logic signed [33:0] cx [0:N];
  logic signed [33:0] cy [0:N];
  logic signed [33:0] cz [0:N];
  logic [1:0]         cq [0:N];

  // angle in [0, pi/2) from the low 30 bits
  assign zprod = 61'(uniform_v[29:0]) * 61'(bmg_pkg::HalfPiQ30);

  always_ff @(posedge clk) begin
    cx[0] <= bmg_pkg::CordicGain;
    cy[0] <= '0;
    cz[0] <= signed'({3'd0, zprod[60:30]});
    cq[0] <= uniform_v[31:30];
  end

  // rotation stages
  for (genvar g = 0; g < N; g++) begin : g_rot
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    assign dx = cy[g] >>> g;
    assign dy = cx[g] >>> g;
    always_ff @(posedge clk) begin
      if (!cz[g][33]) begin
        cx[g+1] <= cx[g] - dx;
        cy[g+1] <= cy[g] + dy;
        cz[g+1] <= cz[g] - bmg_pkg::atan_q30(g);
      end else begin
        cx[g+1] <= cx[g] + dx;
        cy[g+1] <= cy[g] - dy;
        cz[g+1] <= cz[g] + bmg_pkg::atan_q30(g);
      end
      cq[g+1] <= cq[g];
    end
  end

  // quadrant rotation by multiples of 90 degrees
  always_ff @(posedge clk) begin
    case (cq[N])
      2'd0: begin
        cos_val <= cx[N];
        sin_val <= cy[N];
      end
      2'd1: begin
        cos_val <= -cy[N];
        sin_val <= cx[N];
      end
      2'd2: begin
        cos_val <= -cx[N];
        sin_val <= -cy[N];
      end
      default: begin
        cos_val <= cy[N];
        sin_val <= -cx[N];
      end
    endcase
  end

endmodule

// File: rtl/bmg_scale.sv
// ----------------------------------------------------------------------------
// bmg_scale: scale by std_dev, multiply by trig terms, add mean, saturate
// Three register stages; the sine sample is zeroed when not wanted.
// ----------------------------------------------------------------------------
module bmg_scale (
  input  logic               clk,
  input  logic               rst,
  input  bmg_pkg::ctl_t      in_ctl,
  input  logic [30:0]        radius,
  input  logic signed [33:0] cos_val,
  input  logic signed [33:0] sin_val,
  input  logic [31:0]        mean,
  input  logic [31:0]        std_dev,
  output logic               done,
  output logic [31:0]        first_sample,
  output logic [31:0]        second_sample,
  output logic               second_valid
);

  logic [62:0]   pfull;
  logic [34:0]   p;
  logic          c_neg, s_neg;
  logic [32:0]   c_abs, s_abs;
  logic [33:0]   c_mag_in, s_mag_in;
  bmg_pkg::ctl_t ctl1;

  logic [52:0]   c_hi, c_lo, s_hi, s_lo;
  logic          c_neg2, s_neg2;
  bmg_pkg::ctl_t ctl2;

  logic [52:0]   c_mag, s_mag;
  logic [31:0]   c_res, s_res;

  // saturating mean +/- magnitude
  function automatic logic [31:0] add_sat(input logic [31:0] m, input logic neg,
                                          input logic [37:0] mag);
    logic signed [39:0] mx;
    logic signed [39:0] gx;
    logic signed [39:0] s;
    mx = signed'({{8{m[31]}}, m});
    gx = signed'({2'd0, mag});
    s  = neg ? mx - gx : mx + gx;
    if (s > 40'sd2147483647)        return 32'h7FFF_FFFF;
    else if (s < -40'sd2147483648) return 32'h8000_0000;
    else                           return s[31:0];
  endfunction

  // stage 1: radius times std_dev, trig to sign and magnitude
  assign pfull    = 63'(std_dev) * 63'(radius);
  assign c_mag_in = cos_val[33] ? 34'(-cos_val) : 34'(cos_val);
  assign s_mag_in = sin_val[33] ? 34'(-sin_val) : 34'(sin_val);

  always_ff @(posedge clk) begin
    p     <= pfull[62:28];
    c_neg <= cos_val[33];
    s_neg <= sin_val[33];
    c_abs <= c_mag_in[32:0];
    s_abs <= s_mag_in[32:0];
    if (rst) ctl1 <= '0;
    else     ctl1 <= in_ctl;
  end

  // stage 2: split products
  always_ff @(posedge clk) begin
    c_hi   <= 53'(p) * 53'(c_abs[32:15]);
    c_lo   <= 53'(p) * 53'(c_abs[14:0]);
    s_hi   <= 53'(p) * 53'(s_abs[32:15]);
    s_lo   <= 53'(p) * 53'(s_abs[14:0]);
    c_neg2 <= c_neg;
    s_neg2 <= s_neg;
    if (rst) ctl2 <= '0;
    else     ctl2 <= ctl1;
  end

  // stage 3: recombine, add mean, saturate
  assign c_mag = (c_hi + (c_lo >> 15)) >> 15;
  assign s_mag = (s_hi + (s_lo >> 15)) >> 15;
  assign c_res = add_sat(mean, c_neg2, c_mag[37:0]);
  assign s_res = add_sat(mean, s_neg2, s_mag[37:0]);

  always_ff @(posedge clk) begin
    first_sample  <= c_res;
    second_sample <= ctl2.keep ? s_res : 32'd0;
    second_valid  <= ctl2.keep;
    if (rst) done <= 1'b0;
    else     done <= ctl2.valid;
  end

endmodule

// File: rtl/box_muller_gaussian_generator.sv
// ----------------------------------------------------------------------------
// box_muller_gaussian_generator: Gaussian pair from two uniforms
// Usage:
//   A request is taken on every rising edge with start high and busy low.
//   busy is always low, so one request can be taken every cycle.
//   uniform_u and uniform_v are 0.32 fractions; keep_second asks for the
//   sine sample as well.
//   The pair comes out marked by a one-cycle done strobe, in request
//   order. Throughput is one pair per cycle; the radius path runs
//   through the 30 log squaring stages and the 31 root stages.
//   The cosine/sine path (32 stages) is delayed to meet the radius.
//   The receiver cannot stall; results must be taken as they appear.
//   Config: cfg_we writes cfg_data to register cfg_index (0 mean, 1
//   std_dev) at once; write only while no requests are in flight.
//   Reset (synchronous, rst high) empties the pipeline, sets mean to 0
//   and std_dev to 1.0.
// ----------------------------------------------------------------------------
module box_muller_gaussian_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] uniform_u,
  input  logic [31:0] uniform_v,
  input  logic        keep_second,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [31:0] first_sample,
  output logic [31:0] second_sample,
  output logic        second_valid
);

  localparam int unsigned NDly = bmg_pkg::TrigDelay;

  logic [31:0]        mean;
  logic [31:0]        std_dev;
  bmg_pkg::ctl_t      in_ctl;
  bmg_pkg::ctl_t      rad_ctl;
  logic [30:0]        radius;
  logic signed [33:0] cos_raw, sin_raw;
  logic signed [33:0] dcos [0:NDly-1];
  logic signed [33:0] dsin [0:NDly-1];

  assign busy = 1'b0;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mean    <= '0;
      std_dev <= bmg_pkg::StdDevRst;
    end else if (cfg_we) begin
      unique case (bmg_pkg::cfg_reg_t'(cfg_index))
        bmg_pkg::CfgMean:   mean    <= cfg_data;
        bmg_pkg::CfgStdDev: std_dev <= cfg_data;
      endcase
    end
  end

  assign in_ctl.valid = start && !busy;
  assign in_ctl.keep  = keep_second;

  bmg_radius u_radius (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (in_ctl),
    .uniform_u (uniform_u),
    .out_ctl   (rad_ctl),
    .radius    (radius)
  );

  bmg_sincos u_sincos (
    .clk       (clk),
    .uniform_v (uniform_v),
    .cos_val   (cos_raw),
    .sin_val   (sin_raw)
  );

  // align trig terms with the radius
  always_ff @(posedge clk) begin
    dcos[0] <= cos_raw;
    dsin[0] <= sin_raw;
    for (int i = 1; i < NDly; i++) begin
      dcos[i] <= dcos[i-1];
      dsin[i] <= dsin[i-1];
    end
  end

  bmg_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .in_ctl        (rad_ctl),
    .radius        (radius),
    .cos_val       (dcos[NDly-1]),
    .sin_val       (dsin[NDly-1]),
    .mean          (mean),
    .std_dev       (std_dev),
    .done          (done),
    .first_sample  (first_sample),
    .second_sample (second_sample),
    .second_valid  (second_valid)
  );

  // every result traces back to a request a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, bmg_pkg::TotalLat))
    else $error("result without matching request");

  // unwanted sine sample reads as zero
  a_second_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !second_valid) |-> (second_sample == 32'd0))
    else $error("second sample not cleared");

endmodule
